// ===== rtl/core/ptc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the pressure and temperature compensation unit.
// No dependencies.
package ptc_pkg;

   localparam logic [15:0] AC1_RESET  = 16'd408;
   localparam logic [15:0] AC2_RESET  = 16'hFFB8;
   localparam logic [15:0] AC3_RESET  = 16'hC7D1;
   localparam logic [15:0] AC4_RESET  = 16'd32741;
   localparam logic [31:0] AC56_RESET = 32'd2146785905;
   localparam logic [15:0] B1_RESET   = 16'd6190;
   localparam logic [15:0] B2_RESET   = 16'd4;
   localparam logic [31:0] MCMD_RESET = 32'd3724086068;

   localparam logic [2:0] REG_AC1  = 3'd0;
   localparam logic [2:0] REG_AC2  = 3'd1;
   localparam logic [2:0] REG_AC3  = 3'd2;
   localparam logic [2:0] REG_AC4  = 3'd3;
   localparam logic [2:0] REG_AC56 = 3'd4;
   localparam logic [2:0] REG_B1   = 3'd5;
   localparam logic [2:0] REG_B2   = 3'd6;
   localparam logic [2:0] REG_MCMD = 3'd7;

   localparam logic OP_TEMP     = 1'b0;
   localparam logic OP_PRESSURE = 1'b1;

   typedef struct packed {
      logic        start;
      logic        is_div;
      logic [31:0] a;
      logic [31:0] b;
   } alu_ctl_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } alu_sts_type;

   // Signed division by 2**k, truncating toward zero.
   function automatic logic [31:0] sdiv_pow2(input logic [31:0] a, input logic [4:0] k);
      logic [31:0] bias;
      bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
      return 32'($signed(a + bias) >>> k);
   endfunction

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

// ===== rtl/core/ptc_alu.sv =====
`timescale 1ns / 1ps
// Bit-serial unit: 32-bit wrapping multiply or unsigned 32-bit divide, one bit per cycle.
// Depends on ptc_pkg.
module ptc_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  ptc_pkg::alu_ctl_type ctl,
   output ptc_pkg::alu_sts_type sts
);
   import ptc_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        is_div_ff, is_div_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [31:0] acc_ff, acc_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      is_div_in = is_div_ff;
      cnt_in    = cnt_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      shifted   = {acc_ff, b_ff[31]};
      diff      = shifted - {1'b0, a_ff};
      if (ctl.start) begin
         busy_in   = 1'b1;
         is_div_in = ctl.is_div;
         cnt_in    = 5'd0;
         a_in      = ctl.a;
         b_in      = ctl.b;
         acc_in    = 32'd0;
      end else if (busy_ff) begin
         if (is_div_ff) begin
            if (!diff[32]) begin
               acc_in = diff[31:0];
               b_in   = {b_ff[30:0], 1'b1};
            end else begin
               acc_in = shifted[31:0];
               b_in   = {b_ff[30:0], 1'b0};
            end
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[30:0], 1'b0};
            b_in = {1'b0, b_ff[31:1]};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      is_div_ff <= is_div_in;
      cnt_ff    <= cnt_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      acc_ff    <= acc_in;
   end

   assign sts.done   = done_ff;
   assign sts.result = is_div_ff ? b_ff : acc_ff;

endmodule

// ===== rtl/core/pressure_temperature_compensation_unit.sv =====
`timescale 1ns / 1ps
// Top level of the barometer compensation unit: registers, sequencer and result stage.
// Depends on ptc_pkg and ptc_alu.
//
//   Group   Direction  Contents
//   req_    in         tuser: operation; tdata: raw_reading
//   rsp_    out        tuser: kind, divide_error; tdata: value
//   csr_    in         write enable, register index, write data
//
// Each operation runs on the shared bit-serial multiply and divide unit, and the result is then
// handed to the output register; the input is ready again only once a temperature or pressure
// beat has been handed off. A zero divisor ends the beat early. Reset is synchronous and
// restores the coefficient reset values and clears B5. A finished result waits in the output
// register while the next beat is taken; a second one stalls the input until the first has
// been taken.
module pressure_temperature_compensation_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // bit 0: operation
   input  logic [15:0] req_tdata,   // bits 15:0: raw_reading
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // bit 0: kind, bit 1: divide_error
   output logic [31:0] rsp_tdata,   // bits 31:0: value
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import ptc_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   localparam logic [3:0] ST_T1  = 4'd0;
   localparam logic [3:0] ST_T2  = 4'd1;
   localparam logic [3:0] ST_P1  = 4'd2;
   localparam logic [3:0] ST_P2  = 4'd3;
   localparam logic [3:0] ST_P3  = 4'd4;
   localparam logic [3:0] ST_P4  = 4'd5;
   localparam logic [3:0] ST_P5  = 4'd6;
   localparam logic [3:0] ST_P6  = 4'd7;
   localparam logic [3:0] ST_P7  = 4'd8;
   localparam logic [3:0] ST_P8  = 4'd9;
   localparam logic [3:0] ST_P9  = 4'd10;
   localparam logic [3:0] ST_P10 = 4'd11;
   localparam logic [3:0] ST_P11 = 4'd12;

   logic [15:0] ac1_ff, ac2_ff, ac3_ff, ac4_ff, b1_ff, b2_ff;
   logic [31:0] ac56_ff, mcmd_ff;
   logic [31:0] b5_ff, b5_in;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic        op_ff, op_in;
   logic [15:0] raw_ff, raw_in;
   logic        nq_ff, nq_in;
   logic [31:0] x1_ff, x1_in, x2_ff, x2_in, sq_ff, sq_in, b6_ff, b6_in;
   logic [31:0] b3_ff, b3_in, b4_ff, b4_in, b7_ff, b7_in, p_ff, p_in, den_ff, den_in;
   logic [31:0] res_val_ff, res_val_in;
   logic        res_err_ff, res_err_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in, rsp_err_ff, rsp_err_in;
   logic [31:0] rsp_val_ff, rsp_val_in;

   alu_ctl_type ctl;
   alu_sts_type sts;

   logic [31:0] r, t0, t1, t2, mc_sh;

   ptc_alu u_alu (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .sts   (sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ff  <= AC1_RESET;
         ac2_ff  <= AC2_RESET;
         ac3_ff  <= AC3_RESET;
         ac4_ff  <= AC4_RESET;
         ac56_ff <= AC56_RESET;
         b1_ff   <= B1_RESET;
         b2_ff   <= B2_RESET;
         mcmd_ff <= MCMD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_AC1:  ac1_ff  <= csr_wdata[15:0];
            REG_AC2:  ac2_ff  <= csr_wdata[15:0];
            REG_AC3:  ac3_ff  <= csr_wdata[15:0];
            REG_AC4:  ac4_ff  <= csr_wdata[15:0];
            REG_AC56: ac56_ff <= csr_wdata;
            REG_B1:   b1_ff   <= csr_wdata[15:0];
            REG_B2:   b2_ff   <= csr_wdata[15:0];
            REG_MCMD: mcmd_ff <= csr_wdata;
            default:  ;
         endcase
      end
   end

   assign mc_sh = {{5{mcmd_ff[31]}}, mcmd_ff[31:16], 11'd0};

   always_comb begin
      ctl.start  = 1'b0;
      ctl.is_div = 1'b0;
      ctl.a      = 32'd0;
      ctl.b      = 32'd0;
      unique case (step_ff)
         ST_T1: begin
            ctl.a = {16'd0, raw_ff} - {16'd0, ac56_ff[15:0]};
            ctl.b = {16'd0, ac56_ff[31:16]};
         end
         ST_T2: begin
            ctl.is_div = 1'b1;
            ctl.a      = den_ff[31] ? (32'd0 - den_ff) : den_ff;
            ctl.b      = mc_sh[31] ? (32'd0 - mc_sh) : mc_sh;
         end
         ST_P1: begin
            ctl.a = b6_ff;
            ctl.b = b6_ff;
         end
         ST_P2: begin
            ctl.a = sext16(b2_ff);
            ctl.b = sq_ff;
         end
         ST_P3: begin
            ctl.a = sext16(ac2_ff);
            ctl.b = b6_ff;
         end
         ST_P4: begin
            ctl.a = sext16(ac3_ff);
            ctl.b = b6_ff;
         end
         ST_P5: begin
            ctl.a = sext16(b1_ff);
            ctl.b = sq_ff;
         end
         ST_P6: begin
            ctl.a = {16'd0, ac4_ff};
            ctl.b = x2_ff + 32'd32768;
         end
         ST_P7: begin
            ctl.a = {16'd0, raw_ff} - b3_ff;
            ctl.b = 32'd50000;
         end
         ST_P8: begin
            ctl.is_div = 1'b1;
            ctl.a      = b4_ff;
            ctl.b      = b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0};
         end
         ST_P9: begin
            ctl.a = sdiv_pow2(p_ff, 5'd8);
            ctl.b = sdiv_pow2(p_ff, 5'd8);
         end
         ST_P10: begin
            ctl.a = x1_ff;
            ctl.b = 32'd3038;
         end
         ST_P11: begin
            ctl.a = 32'hFFFFE343;
            ctl.b = p_ff;
         end
         default: ;
      endcase
      // The unit takes the divisor in a and the dividend in b.
      ctl.start = (state_ff == S_RUN);
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      op_in        = op_ff;
      raw_in       = raw_ff;
      nq_in        = nq_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      sq_in        = sq_ff;
      b6_in        = b6_ff;
      b3_in        = b3_ff;
      b4_in        = b4_ff;
      b7_in        = b7_ff;
      p_in         = p_ff;
      den_in       = den_ff;
      b5_in        = b5_ff;
      res_val_in   = res_val_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_val_in   = rsp_val_ff;
      r            = sts.result;
      t0           = 32'd0;
      t1           = 32'd0;
      t2           = 32'd0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_tuser;
               raw_in     = req_tdata;
               b6_in      = b5_ff - 32'd4000;
               step_in    = (req_tuser == OP_PRESSURE) ? ST_P1 : ST_T1;
               res_val_in = 32'd0;
               res_err_in = 1'b0;
               state_in   = S_RUN;
            end
         end
         S_RUN: begin
            if (step_ff == ST_T2) begin
               nq_in = den_ff[31] ^ mc_sh[31];
            end
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (sts.done) begin
               state_in = S_RUN;
               step_in  = step_ff + 4'd1;
               unique case (step_ff)
                  ST_T1: begin
                     t0     = sdiv_pow2(r, 5'd15);
                     x1_in  = t0;
                     den_in = t0 + sext16(mcmd_ff[15:0]);
                     if (den_in == 32'd0) begin
                        res_err_in = 1'b1;
                        state_in   = S_OUT;
                     end
                  end
                  ST_T2: begin
                     t0         = nq_ff ? (32'd0 - r) : r;
                     t1         = x1_ff + t0;
                     b5_in      = t1;
                     res_val_in = sdiv_pow2(t1 + 32'd8, 5'd4);
                     state_in   = S_OUT;
                  end
                  ST_P1: sq_in = sdiv_pow2(r, 5'd12);
                  ST_P2: x1_in = sdiv_pow2(r, 5'd11);
                  ST_P3: begin
                     t0    = sdiv_pow2(r, 5'd11);
                     t1    = {{14{ac1_ff[15]}}, ac1_ff, 2'b00};
                     b3_in = sdiv_pow2(t1 + x1_ff + t0 + 32'd2, 5'd2);
                  end
                  ST_P4: x1_in = sdiv_pow2(r, 5'd13);
                  ST_P5: begin
                     t0    = sdiv_pow2(r, 5'd16);
                     x2_in = sdiv_pow2(x1_ff + t0 + 32'd2, 5'd2);
                  end
                  ST_P6: b4_in = {15'd0, r[31:15]};
                  ST_P7: begin
                     b7_in = r;
                     if (b4_ff == 32'd0) begin
                        res_err_in = 1'b1;
                        state_in   = S_OUT;
                     end
                  end
                  ST_P8:  p_in  = b7_ff[31] ? {r[30:0], 1'b0} : r;
                  ST_P9:  x1_in = r;
                  ST_P10: x1_in = sdiv_pow2(r, 5'd16);
                  ST_P11: begin
                     t0         = sdiv_pow2(r, 5'd16);
                     t2         = sdiv_pow2(x1_ff + t0 + 32'd3791, 5'd4);
                     res_val_in = p_ff + t2;
                     state_in   = S_OUT;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = op_ff;
               rsp_err_in   = res_err_ff;
               rsp_val_in   = res_val_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         b5_ff        <= 32'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         b5_ff        <= b5_in;
      end
      step_ff    <= step_in;
      op_ff      <= op_in;
      raw_ff     <= raw_in;
      nq_ff      <= nq_in;
      x1_ff      <= x1_in;
      x2_ff      <= x2_in;
      sq_ff      <= sq_in;
      b6_ff      <= b6_in;
      b3_ff      <= b3_in;
      b4_ff      <= b4_in;
      b7_ff      <= b7_in;
      p_ff       <= p_in;
      den_ff     <= den_in;
      res_val_ff <= res_val_in;
      res_err_ff <= res_err_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_val_ff  <= rsp_val_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_err_ff, rsp_kind_ff};
   assign rsp_tdata  = rsp_val_ff;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the pressure and temperature compensation unit: random and directed readings
// are checked against a behavioural model of the compensation arithmetic. Depends on ptc_pkg.
module tb;
   import ptc_pkg::*;

   typedef struct packed {
      logic        kind;
      logic        divide_error;
      logic [31:0] value;
   } comp_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   logic [15:0] m_ac1, m_ac2, m_ac3, m_ac4, m_b1, m_b2;
   logic [31:0] m_ac56, m_mcmd, m_b5;

   comp_result_type pending_results[$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  send_idling = 1'b1;
   bit  recv_idling = 1'b1;
   bit  hold_recv = 1'b0;
   localparam int WATCHDOG_LIMIT = 40000;

   pressure_temperature_compensation_unit uut (.*);

   always #5 clock = ~clock;

   function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic comp_result_type compensate(input logic op, input logic [15:0] raw);
      comp_result_type r;
      logic [31:0] ac5, ac6, mc, md, x1, x2, x3, den, b6, sq, b3, b4, b7, p, h;
      r.kind = op;
      r.divide_error = 1'b0;
      r.value = '0;
      if (op == OP_TEMP) begin
         ac5 = {16'd0, m_ac56[31:16]};
         ac6 = {16'd0, m_ac56[15:0]};
         mc = {{16{m_mcmd[31]}}, m_mcmd[31:16]};
         md = {{16{m_mcmd[15]}}, m_mcmd[15:0]};
         x1 = div_trunc(({16'd0, raw} - ac6) * ac5, 32'd32768);
         den = x1 + md;
         if (den == 0) begin
            r.divide_error = 1'b1;
         end else begin
            x2 = div_trunc(mc * 32'd2048, den);
            m_b5 = x1 + x2;
            r.value = div_trunc(m_b5 + 32'd8, 32'd16);
         end
      end else begin
         b6 = m_b5 - 32'd4000;
         sq = div_trunc(b6 * b6, 32'd4096);
         x1 = div_trunc({{16{m_b2[15]}}, m_b2} * sq, 32'd2048);
         x2 = div_trunc({{16{m_ac2[15]}}, m_ac2} * b6, 32'd2048);
         x3 = x1 + x2;
         b3 = div_trunc({{16{m_ac1[15]}}, m_ac1} * 32'd4 + x3 + 32'd2, 32'd4);
         x1 = div_trunc({{16{m_ac3[15]}}, m_ac3} * b6, 32'd8192);
         x2 = div_trunc({{16{m_b1[15]}}, m_b1} * sq, 32'd65536);
         x3 = div_trunc(x1 + x2 + 32'd2, 32'd4);
         b4 = ({16'd0, m_ac4} * (x3 + 32'd32768)) / 32'd32768;
         b7 = ({16'd0, raw} - b3) * 32'd50000;
         if (b4 == 0) begin
            r.divide_error = 1'b1;
         end else begin
            p = (b7 < 32'h8000_0000) ? ((b7 * 32'd2) / b4) : ((b7 / b4) * 32'd2);
            h = div_trunc(p, 32'd256);
            x1 = div_trunc((h * h) * 32'd3038, 32'd65536);
            x2 = div_trunc((32'd0 - 32'd7357) * p, 32'd65536);
            r.value = p + div_trunc(x1 + x2 + 32'd3791, 32'd16);
         end
      end
      return r;
   endfunction

   task automatic send_reading(input logic op, input logic [15:0] raw);
      int gap;
      if (send_idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= raw;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(compensate(op, raw));
   endtask

   task automatic drain_results();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_coeff(input logic [2:0] idx, input logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_AC1:  m_ac1 = data[15:0];
         REG_AC2:  m_ac2 = data[15:0];
         REG_AC3:  m_ac3 = data[15:0];
         REG_AC4:  m_ac4 = data[15:0];
         REG_AC56: m_ac56 = data;
         REG_B1:   m_b1 = data[15:0];
         REG_B2:   m_b2 = data[15:0];
         default:  m_mcmd = data;
      endcase
   endtask

   task automatic load_coeffs(input logic [15:0] a1, a2, a3, a4, input logic [31:0] a56,
                              input logic [15:0] b1, b2, input logic [31:0] mcmd);
      drain_results();
      write_coeff(REG_AC1, {16'd0, a1});
      write_coeff(REG_AC2, {16'd0, a2});
      write_coeff(REG_AC3, {16'd0, a3});
      write_coeff(REG_AC4, {16'd0, a4});
      write_coeff(REG_AC56, a56);
      write_coeff(REG_B1, {16'd0, b1});
      write_coeff(REG_B2, {16'd0, b2});
      write_coeff(REG_MCMD, mcmd);
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_coeffs();
      send_reading(OP_PRESSURE, 16'd23843);
      send_reading(OP_TEMP, 16'd27898);
      send_reading(OP_PRESSURE, 16'd23843);
      send_reading(OP_TEMP, 16'h0000);
      send_reading(OP_PRESSURE, 16'hFFFF);
      send_reading(OP_TEMP, 16'hFFFF);
      send_reading(OP_PRESSURE, 16'h0000);
   endtask

   task automatic test_divide_by_zero();
      // AC5 of zero makes X1 zero, so MD of zero gives a zero temperature divisor.
      load_coeffs(16'd408, 16'hFFB8, 16'hC7D1, 16'd0, 32'h0000_1234, 16'd6190, 16'd4,
                  32'h8000_0000);
      send_reading(OP_TEMP, 16'd1000);
      send_reading(OP_PRESSURE, 16'd5000);
      load_coeffs(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000,
                  32'h8000_0001);
      send_reading(OP_TEMP, 16'hFFFF);
      send_reading(OP_PRESSURE, 16'hFFFF);
      send_reading(OP_TEMP, 16'h0000);
      send_reading(OP_PRESSURE, 16'h0000);
      load_coeffs(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001, 32'h0000_0000, 16'h8000, 16'h7FFF,
                  32'h7FFF_7FFF);
      send_reading(OP_TEMP, 16'h8000);
      send_reading(OP_PRESSURE, 16'h8000);
      send_reading(OP_PRESSURE, 16'h7FFF);
   endtask

   task automatic test_random_readings(input int count, input bit random_coeffs);
      for (int i = 0; i < count; i++) begin
         if (random_coeffs && i % 200 == 0)
            load_coeffs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        $urandom, 16'($urandom), 16'($urandom), $urandom);
         send_reading(1'($urandom_range(0, 1)), 16'($urandom));
      end
   endtask

   task automatic test_backpressure();
      drain_results();
      load_coeffs(AC1_RESET, AC2_RESET, AC3_RESET, AC4_RESET, AC56_RESET, B1_RESET, B2_RESET,
                  MCMD_RESET);
      hold_recv = 1'b1;
      send_idling = 1'b0;
      for (int i = 0; i < 6; i++) send_reading(1'($urandom_range(0, 1)), 16'($urandom));
      send_idling = 1'b1;
      drain_results();
   endtask

   always @(posedge clock) begin
      int hold_count;
      if (hold_recv) begin
         hold_count = 0;
         rsp_tready <= 1'b0;
         while (hold_count < 3000) begin
            @(posedge clock);
            hold_count++;
         end
         hold_recv = 1'b0;
      end else if (recv_idling && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      comp_result_type expected, actual;
      if (!reset && rsp_tvalid && rsp_tready) begin
         actual = '{kind: rsp_tuser[0], divide_error: rsp_tuser[1], value: rsp_tdata};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected beat: %p", actual);
         end else begin
            expected = pending_results.pop_front();
            if (actual !== expected) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %p, got %p", expected, actual);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      m_ac1 = AC1_RESET; m_ac2 = AC2_RESET; m_ac3 = AC3_RESET; m_ac4 = AC4_RESET;
      m_ac56 = AC56_RESET; m_b1 = B1_RESET; m_b2 = B2_RESET; m_mcmd = MCMD_RESET;
      m_b5 = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_coeffs();
      test_divide_by_zero();
      test_backpressure();
      test_random_readings(1300, 1'b1);
      load_coeffs(AC1_RESET, AC2_RESET, AC3_RESET, AC4_RESET, AC56_RESET, B1_RESET, B2_RESET,
                  MCMD_RESET);
      send_idling = 1'b0;
      recv_idling = 1'b0;
      test_random_readings(250, 1'b0);
      drain_results();
      if (mismatches == 0 && pending_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
